FILE: src/rti_pkg.sv
`default_nettype none
package rti_pkg;
   localparam int DIST_FRAC = 16;
   localparam int EPS_WIDTH = 40;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 40'd68719;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIR_Z    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EPSILON  = 3'd6;
   localparam int CSR_DATA_WIDTH = 64;
endpackage
`default_nettype wire

FILE: src/rti_if.sv
`default_nettype none
interface rti_req_if #(parameter int COORD_WIDTH = 16);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] vert0_x, vert0_y, vert0_z;
   logic signed [COORD_WIDTH-1:0] vert1_x, vert1_y, vert1_z;
   logic signed [COORD_WIDTH-1:0] vert2_x, vert2_y, vert2_z;
   modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                   vert2_x, vert2_y, vert2_z, input ready);
   modport sink (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                 vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface rti_rsp_if #(parameter int DIST_WIDTH = 32);
   logic valid;
   logic ready;
   logic hit;
   logic signed [DIST_WIDTH-1:0] distance;
   modport source (output valid, hit, distance, input ready);
   modport sink (input valid, hit, distance, output ready);
endinterface

interface rti_csr_if;
   logic valid;
   logic ready;
   logic [rti_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [rti_pkg::CSR_DATA_WIDTH-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/rti_geom.sv
`default_nettype none
// Geometry stages: edges, cross products, dot products and the hit test.
// Four register stages; each advances when the stage after it moves.
module rti_geom #(
   parameter int CW = 16,
   parameter int NW = 3 * CW + 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  wire logic in_valid,
   input  wire logic signed [CW-1:0] v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z,
   input  wire logic signed [CW-1:0] ox, oy, oz, dx, dy, dz,
   input  wire logic [rti_pkg::EPS_WIDTH-1:0] eps,
   output logic out_valid,
   output logic out_hit,
   output logic signed [NW-1:0] out_tn,
   output logic signed [NW-1:0] out_det
);
   import rti_pkg::*;
   localparam int EW = CW + 1;
   localparam int PW = 2 * EW + 1;

   // Stage 1: edges and origin offset.
   logic v1_ff;
   logic signed [EW-1:0] e1_ff [3], e2_ff [3], s_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= in_valid;
      if (advance) begin
         e1_ff[0] <= EW'(v1x) - EW'(v0x);
         e1_ff[1] <= EW'(v1y) - EW'(v0y);
         e1_ff[2] <= EW'(v1z) - EW'(v0z);
         e2_ff[0] <= EW'(v2x) - EW'(v0x);
         e2_ff[1] <= EW'(v2y) - EW'(v0y);
         e2_ff[2] <= EW'(v2z) - EW'(v0z);
         s_ff[0]  <= EW'(ox) - EW'(v0x);
         s_ff[1]  <= EW'(oy) - EW'(v0y);
         s_ff[2]  <= EW'(oz) - EW'(v0z);
      end
   end

   // Stage 2: cross products p = dir x e2 and q = s x e1.
   logic v2_ff;
   logic signed [PW-1:0] p_ff [3], q_ff [3];
   logic signed [EW-1:0] e1b_ff [3], e2b_ff [3], sb_ff [3];
   logic signed [EW-1:0] de [3];
   assign de[0] = EW'(dx);
   assign de[1] = EW'(dy);
   assign de[2] = EW'(dz);
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         p_ff[0] <= PW'(de[1] * e2_ff[2]) - PW'(de[2] * e2_ff[1]);
         p_ff[1] <= PW'(de[2] * e2_ff[0]) - PW'(de[0] * e2_ff[2]);
         p_ff[2] <= PW'(de[0] * e2_ff[1]) - PW'(de[1] * e2_ff[0]);
         q_ff[0] <= PW'(s_ff[1] * e1_ff[2]) - PW'(s_ff[2] * e1_ff[1]);
         q_ff[1] <= PW'(s_ff[2] * e1_ff[0]) - PW'(s_ff[0] * e1_ff[2]);
         q_ff[2] <= PW'(s_ff[0] * e1_ff[1]) - PW'(s_ff[1] * e1_ff[0]);
         e1b_ff <= e1_ff;
         e2b_ff <= e2_ff;
         sb_ff  <= s_ff;
      end
   end

   // Stage 3: dot products det, U, V and T.
   logic v3_ff;
   logic signed [NW-1:0] det_ff, un_ff, vn_ff, tn_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         det_ff <= NW'(e1b_ff[0] * p_ff[0]) + NW'(e1b_ff[1] * p_ff[1])
                 + NW'(e1b_ff[2] * p_ff[2]);
         un_ff  <= NW'(sb_ff[0] * p_ff[0]) + NW'(sb_ff[1] * p_ff[1])
                 + NW'(sb_ff[2] * p_ff[2]);
         vn_ff  <= NW'(de[0] * q_ff[0]) + NW'(de[1] * q_ff[1]) + NW'(de[2] * q_ff[2]);
         tn_ff  <= NW'(e2b_ff[0] * q_ff[0]) + NW'(e2b_ff[1] * q_ff[1])
                 + NW'(e2b_ff[2] * q_ff[2]);
      end
   end

   // Stage 4: hit decision against the determinant and epsilon.
   logic v4_ff, hit_ff;
   logic signed [NW-1:0] tn4_ff, det4_ff;
   logic signed [NW:0] uv_sum;
   logic signed [NW:0] eps_ext;
   assign uv_sum  = (NW+1)'(un_ff) + (NW+1)'(vn_ff);
   assign eps_ext = (NW+1)'($signed({1'b0, eps}));
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
      if (advance) begin
         hit_ff <= (det_ff > 0) && ((NW+1)'(det_ff) >= eps_ext) && (un_ff >= 0)
                && (un_ff <= det_ff) && (vn_ff >= 0) && (uv_sum <= (NW+1)'(det_ff));
         tn4_ff  <= tn_ff;
         det4_ff <= det_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_hit   = hit_ff;
   assign out_tn    = tn4_ff;
   assign out_det   = det4_ff;
endmodule
`default_nettype wire

FILE: src/rti_div.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, with saturation.
// Quotient bits above the saturation limit only need to detect overflow,
// so the divider produces DW + 1 magnitude bits and clamps.
module rti_div #(
   parameter int NW = 56,
   parameter int DW = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  wire logic in_valid,
   input  wire logic in_hit,
   input  wire logic signed [NW-1:0] in_num,
   input  wire logic signed [NW-1:0] in_den,
   output logic out_valid,
   output logic out_hit,
   output logic signed [DW-1:0] out_q
);
   import rti_pkg::*;
   localparam int QB = DW + 1;
   localparam int RW = NW + 1;
   localparam int SH = DIST_FRAC;
   // Numerator scaled by 2^SH; quotient above 2^QB saturates anyway.
   localparam int AW = NW + SH;

   logic vld_ff [QB+1];
   logic hit_ff [QB+1];
   logic neg_ff [QB+1];
   logic ovf_ff [QB+1];
   logic [AW-1:0] a_ff [QB+1];
   logic [RW-1:0] r_ff [QB+1];
   logic [RW-1:0] d_ff [QB+1];
   logic [QB-1:0] q_ff [QB+1];

   // Entry: magnitude, and a check that the quotient fits in QB bits.
   logic neg0;
   logic [NW-1:0] mag0;
   logic [AW-1:0] a0;
   assign neg0 = in_num[NW-1];
   assign mag0 = neg0 ? NW'(-in_num) : NW'(in_num);
   assign a0   = {mag0, SH'(0)};

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else if (advance) vld_ff[0] <= in_valid;
      if (advance) begin
         hit_ff[0] <= in_hit;
         neg_ff[0] <= neg0;
         // Overflow if a >= den * 2^QB (den is positive when it matters).
         ovf_ff[0] <= ((AW + QB)'(a0) >= ((AW + QB)'($unsigned(in_den)) << QB));
         a_ff[0]   <= a0;
         // Without overflow the bits of a above the low QB are already below den,
         // so they form the starting remainder.
         r_ff[0]   <= RW'(a0[AW-1:QB]);
         d_ff[0]   <= RW'($unsigned(in_den));
         q_ff[0]   <= '0;
      end
   end

   // Stages: shift in the next numerator bit from the top of QB bits.
   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [RW:0] rs;
      logic [RW:0] diff;
      assign rs   = {r_ff[k], a_ff[k][QB-1-k]};
      assign diff = rs - (RW+1)'(d_ff[k]);
      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else if (advance) vld_ff[k+1] <= vld_ff[k];
         if (advance) begin
            hit_ff[k+1] <= hit_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            a_ff[k+1]   <= a_ff[k];
            d_ff[k+1]   <= d_ff[k];
            if (!diff[RW]) begin
               r_ff[k+1] <= diff[RW-1:0];
               q_ff[k+1] <= {q_ff[k][QB-2:0], 1'b1};
            end else begin
               r_ff[k+1] <= rs[RW-1:0];
               q_ff[k+1] <= {q_ff[k][QB-2:0], 1'b0};
            end
         end
      end
   end

   // Output: clamp and sign.
   logic [QB-1:0] lim;
   logic [QB-1:0] qsat;
   assign lim  = neg_ff[QB] ? QB'({1'b1, (DW-1)'(0)}) : QB'({1'b0, {(DW-1){1'b1}}});
   assign qsat = (ovf_ff[QB] || (q_ff[QB] > lim)) ? lim : q_ff[QB];
   assign out_valid = vld_ff[QB];
   assign out_hit   = hit_ff[QB];
   assign out_q     = hit_ff[QB] ? (neg_ff[QB] ? DW'(-qsat) : DW'(qsat)) : '0;
endmodule
`default_nettype wire

FILE: src/ray_triangle_intersect_top.sv
`default_nettype none
// Channel | Dir | Beat contents
// req     | in  | vert0_x..vert2_z, one triangle
// rsp     | out | hit, distance
// csr     | in  | index, data (ray origin, direction, epsilon)
// One triangle enters every cycle while rsp does not stall; the pipeline is 4 geometry stages plus
// DIST_WIDTH + 2 divider stages and the output register.
// The whole pipeline freezes while a finished beat waits on rsp; req stays
// ready as long as the output register is empty or being drained.
// Reset is synchronous and restores the ray registers and epsilon.
module ray_triangle_intersect_top #(
   parameter int COORD_WIDTH = 16,
   parameter int DIST_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   rti_req_if.sink   req,
   rti_rsp_if.source rsp,
   rti_csr_if.sink   csr
);
   import rti_pkg::*;
   localparam int NW = 3 * COORD_WIDTH + 8;

   logic signed [COORD_WIDTH-1:0] ox_ff, oy_ff, oz_ff, dx_ff, dy_ff, dz_ff;
   logic [EPS_WIDTH-1:0] eps_ff;

   // Configuration writes.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
         dx_ff <= '0; dy_ff <= '0; dz_ff <= '0;
         eps_ff <= EPS_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_ORIGIN_X: ox_ff <= COORD_WIDTH'(csr.data);
            CSR_ORIGIN_Y: oy_ff <= COORD_WIDTH'(csr.data);
            CSR_ORIGIN_Z: oz_ff <= COORD_WIDTH'(csr.data);
            CSR_DIR_X:    dx_ff <= COORD_WIDTH'(csr.data);
            CSR_DIR_Y:    dy_ff <= COORD_WIDTH'(csr.data);
            CSR_DIR_Z:    dz_ff <= COORD_WIDTH'(csr.data);
            CSR_EPSILON:  eps_ff <= EPS_WIDTH'(csr.data);
            default: ;
         endcase
      end
   end

   // Output register; the pipeline advances when it is free or drained.
   logic out_vld_ff, out_hit_ff;
   logic signed [DIST_WIDTH-1:0] out_dist_ff;
   logic advance;
   assign advance   = !out_vld_ff || rsp.ready;
   assign req.ready = advance;

   logic g_valid, g_hit;
   logic signed [NW-1:0] g_tn, g_det;
   rti_geom #(.CW(COORD_WIDTH), .NW(NW)) u_geom (
      .clock, .reset, .advance, .in_valid(req.valid),
      .v0x(req.vert0_x), .v0y(req.vert0_y), .v0z(req.vert0_z),
      .v1x(req.vert1_x), .v1y(req.vert1_y), .v1z(req.vert1_z),
      .v2x(req.vert2_x), .v2y(req.vert2_y), .v2z(req.vert2_z),
      .ox(ox_ff), .oy(oy_ff), .oz(oz_ff), .dx(dx_ff), .dy(dy_ff), .dz(dz_ff),
      .eps(eps_ff),
      .out_valid(g_valid), .out_hit(g_hit), .out_tn(g_tn), .out_det(g_det)
   );

   logic d_valid, d_hit;
   logic signed [DIST_WIDTH-1:0] d_q;
   rti_div #(.NW(NW), .DW(DIST_WIDTH)) u_div (
      .clock, .reset, .advance, .in_valid(g_valid), .in_hit(g_hit),
      .in_num(g_tn), .in_den(g_det),
      .out_valid(d_valid), .out_hit(d_hit), .out_q(d_q)
   );

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (advance) out_vld_ff <= d_valid;
      if (advance) begin
         out_hit_ff  <= d_hit;
         out_dist_ff <= d_q;
      end
   end
   assign rsp.valid    = out_vld_ff;
   assign rsp.hit      = out_hit_ff;
   assign rsp.distance = out_dist_ff;
endmodule
`default_nettype wire
